// ----- rtl/assert_macros.svh -----
// Assertion helpers: clocked implication and next-cycle implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/hsvr_pkg.sv -----
`default_nettype none

package hsvr_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned CHAN_W        = 8;
    localparam int unsigned RGB_W         = 3 * CHAN_W;
    localparam int unsigned RED_LSB       = 2 * CHAN_W;
    localparam int unsigned GRN_LSB       = CHAN_W;
    localparam int unsigned BLU_LSB       = 0;

    // hexcone sector, red..yellow..green..cyan..blue..magenta
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic    grey;
        sector_t sector;
    } hsvr_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/hsvr_if.sv -----
`default_nettype none

interface hsvr_hsv_if
    import hsvr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+1:0] hue;
    logic        [FRAC_BITS:0]   saturation;
    logic        [FRAC_BITS:0]   brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvr_rgb_if
    import hsvr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] rgb_word;

    modport source (output valid, rgb_word, input ready);
    modport sink   (input valid, rgb_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsvr_prep.sv -----
`default_nettype none

module hsvr_prep
    import hsvr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        up_valid,
    output logic                             up_ready,
    input  wire logic signed [FRAC_BITS+1:0] hue,
    input  wire logic        [FRAC_BITS:0]   saturation,
    input  wire logic        [FRAC_BITS:0]   brightness,
    output logic                             dn_valid,
    input  wire logic                        dn_ready,
    output hsvr_ctl_t                        ctl,
    output logic [FRAC_BITS-1:0]             frac,
    output logic [FRAC_BITS:0]               sat,
    output logic [FRAC_BITS+CHAN_W-1:0]      vs
);

    localparam int unsigned VS_W = FRAC_BITS + CHAN_W;
    localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    logic                  valid_reg;
    hsvr_ctl_t             ctl_reg,  ctl_next;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;
    logic [FRAC_BITS:0]    sat_reg,  sat_next;
    logic [VS_W-1:0]       vs_reg,   vs_next;
    logic [FRAC_BITS-1:0]  hue_c;
    logic [FRAC_BITS+2:0]  h6;
    logic [FRAC_BITS:0]    bri_c;
    logic [VS_W:0]         vs_full;

    // out-of-range hue (negative or >= 1.0) falls back to 0
    assign hue_c   = (hue[FRAC_BITS+1:FRAC_BITS] == 2'b00) ? hue[FRAC_BITS-1:0] : '0;
    assign h6      = {1'b0, hue_c, 2'b00} + {2'b00, hue_c, 1'b0};
    assign sat_next = saturation[FRAC_BITS] ? ONE_FX : saturation;
    assign bri_c   = brightness[FRAC_BITS] ? ONE_FX : brightness;
    // brightness * 255 as shift and subtract
    assign vs_full = {bri_c, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, bri_c};
    assign vs_next = vs_full[VS_W-1:0];
    assign frac_next       = h6[FRAC_BITS-1:0];
    assign ctl_next.grey   = (saturation == '0);
    assign ctl_next.sector = sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctl_reg  <= ctl_next;
            frac_reg <= frac_next;
            sat_reg  <= sat_next;
            vs_reg   <= vs_next;
        end
    end

    assign dn_valid = valid_reg;
    assign ctl      = ctl_reg;
    assign frac     = frac_reg;
    assign sat      = sat_reg;
    assign vs       = vs_reg;

endmodule

`default_nettype wire

// ----- rtl/hsvr_mult.sv -----
`default_nettype none

module hsvr_mult
    import hsvr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire hsvr_ctl_t                     up_ctl,
    input  wire logic [FRAC_BITS-1:0]          frac,
    input  wire logic [FRAC_BITS:0]            sat,
    input  wire logic [FRAC_BITS+CHAN_W-1:0]   vs,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output hsvr_ctl_t                          dn_ctl,
    output logic [CHAN_W-1:0]                  vi,
    output logic [CHAN_W-1:0]                  aa,
    output logic [2*FRAC_BITS+CHAN_W:0]        hi_b,
    output logic [2*FRAC_BITS+CHAN_W-1:0]      lo_b,
    output logic [2*FRAC_BITS+CHAN_W:0]        hi_c,
    output logic [2*FRAC_BITS+CHAN_W-1:0]      lo_c
);

    localparam int unsigned F    = FRAC_BITS;
    localparam int unsigned VS_W = F + CHAN_W;
    localparam int unsigned T_W  = 2 * F + 1;
    localparam int unsigned HI_W = VS_W + F + 1;
    localparam int unsigned LO_W = VS_W + F;
    localparam logic [F:0]     ONE_FX = {1'b1, {F{1'b0}}};
    localparam logic [T_W-1:0] ONE_SQ = {1'b1, {(2 * F){1'b0}}};

    // stage 2: s*f, s*(1-f), vs*(1-s)
    logic                valid2_reg;
    logic                rdy2;
    hsvr_ctl_t           ctl2_reg;
    logic [VS_W-1:0]     vs2_reg;
    logic [T_W-1:0]      tb2_reg, tb2_next;
    logic [T_W-1:0]      tc2_reg, tc2_next;
    logic [HI_W-1:0]     ap2_reg, ap2_next;
    logic [T_W-1:0]      sf;
    logic [F:0]          omf;
    logic [F:0]          oms;
    logic [T_W:0]        tc_wide;

    // stage 3: vs * t split into high and low halves of t
    logic                valid3_reg;
    logic                rdy3;
    hsvr_ctl_t           ctl3_reg;
    logic [CHAN_W-1:0]   vi3_reg, aa3_reg;
    logic [HI_W-1:0]     hib3_reg, hib3_next, hic3_reg, hic3_next;
    logic [LO_W-1:0]     lob3_reg, lob3_next, loc3_reg, loc3_next;

    assign sf       = sat * frac;
    assign tb2_next = ONE_SQ - sf;
    assign omf      = ONE_FX - {1'b0, frac};
    assign tc_wide  = {1'b0, ONE_SQ} - sat * omf;
    assign tc2_next = tc_wide[T_W-1:0];
    assign oms      = ONE_FX - sat;
    assign ap2_next = vs * oms;

    assign hib3_next = vs2_reg * tb2_reg[T_W-1:F];
    assign lob3_next = vs2_reg * tb2_reg[F-1:0];
    assign hic3_next = vs2_reg * tc2_reg[T_W-1:F];
    assign loc3_next = vs2_reg * tc2_reg[F-1:0];

    assign rdy3     = !valid3_reg || dn_ready;
    assign rdy2     = !valid2_reg || rdy3;
    assign up_ready = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                valid2_reg <= up_valid;
            end
            if (rdy3)
            begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && up_valid)
        begin
            ctl2_reg <= up_ctl;
            vs2_reg  <= vs;
            tb2_reg  <= tb2_next;
            tc2_reg  <= tc2_next;
            ap2_reg  <= ap2_next;
        end
        if (rdy3 && valid2_reg)
        begin
            ctl3_reg <= ctl2_reg;
            vi3_reg  <= vs2_reg[VS_W-1:F];
            aa3_reg  <= ap2_reg[2*F+CHAN_W-1:2*F];
            hib3_reg <= hib3_next;
            lob3_reg <= lob3_next;
            hic3_reg <= hic3_next;
            loc3_reg <= loc3_next;
        end
    end

    assign dn_valid = valid3_reg;
    assign dn_ctl   = ctl3_reg;
    assign vi       = vi3_reg;
    assign aa       = aa3_reg;
    assign hi_b     = hib3_reg;
    assign lo_b     = lob3_reg;
    assign hi_c     = hic3_reg;
    assign lo_c     = loc3_reg;

endmodule

`default_nettype wire

// ----- rtl/hsvr_pick.sv -----
`default_nettype none
`include "assert_macros.svh"

module hsvr_pick
    import hsvr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire hsvr_ctl_t                     ctl,
    input  wire logic [CHAN_W-1:0]             vi,
    input  wire logic [CHAN_W-1:0]             aa,
    input  wire logic [2*FRAC_BITS+CHAN_W:0]   hi_b,
    input  wire logic [2*FRAC_BITS+CHAN_W-1:0] lo_b,
    input  wire logic [2*FRAC_BITS+CHAN_W:0]   hi_c,
    input  wire logic [2*FRAC_BITS+CHAN_W-1:0] lo_c,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output logic [RGB_W-1:0]                   rgb_word
);

    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned SUM_W = 2 * F + CHAN_W + 2;

    logic               valid_reg;
    logic [RGB_W-1:0]   rgb_reg, rgb_next;
    logic [SUM_W-1:0]   sum_b, sum_c;
    logic [CHAN_W-1:0]  bb, cc;
    logic [CHAN_W-1:0]  r, g, b;

    // floor(vs*t / ONE^3) = (vs*th + floor(vs*tl / ONE)) >> 2F
    assign sum_b = {1'b0, hi_b} + {{(F + 2){1'b0}}, lo_b[2*F+CHAN_W-1:F]};
    assign sum_c = {1'b0, hi_c} + {{(F + 2){1'b0}}, lo_c[2*F+CHAN_W-1:F]};
    assign bb    = sum_b[2*F+CHAN_W-1:2*F];
    assign cc    = sum_c[2*F+CHAN_W-1:2*F];

    always_comb
    begin
        r = vi;
        g = aa;
        b = bb;
        if (ctl.grey)
        begin
            r = vi;
            g = vi;
            b = vi;
        end
        else
        begin
            unique case (ctl.sector)
                SEC_0:   begin r = vi; g = cc; b = aa; end
                SEC_1:   begin r = bb; g = vi; b = aa; end
                SEC_2:   begin r = aa; g = vi; b = cc; end
                SEC_3:   begin r = aa; g = bb; b = vi; end
                SEC_4:   begin r = cc; g = aa; b = vi; end
                SEC_5:   begin r = vi; g = aa; b = bb; end
                default: begin r = vi; g = aa; b = bb; end
            endcase
        end
    end

    assign rgb_next = {r, g, b};
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign dn_valid = valid_reg;
    assign rgb_word = rgb_reg;

    // every scaled term is at most the full value
    `ASSERT_IMPL(a_chan_bound, clk, rst_n, up_valid, aa <= vi && bb <= vi && cc <= vi)
    `ASSERT_NEXT(a_grey_word, clk, rst_n, up_valid && up_ready && ctl.grey, rgb_reg[RED_LSB +: CHAN_W] == rgb_reg[BLU_LSB +: CHAN_W] && rgb_reg[GRN_LSB +: CHAN_W] == rgb_reg[BLU_LSB +: CHAN_W])
    `ASSERT_NEXT(a_red_full, clk, rst_n, up_valid && up_ready && !ctl.grey && ctl.sector == SEC_0, rgb_reg[RED_LSB +: CHAN_W] == $past(vi))

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_packed.sv -----
// HSV to packed RGB converter. Takes one HSV word per clock when not stalled (hue signed with
// FRAC_BITS fraction bits, saturation and brightness 0..1.0) and returns one 24-bit word with
// red in 23..16, green in 15..8 and blue in 7..0. Hue below 0 or at or above 1.0 is treated as
// 0, saturation and brightness above 1.0 are clipped to 1.0, zero saturation gives grey.
// Throughput is one word per clock while the output accepts; there are four register stages:
// clamp and value scaling, the saturation products, the value products, then channel select
// into the output register. Each stage holds its word under back-pressure, so a stalled output
// still lets the earlier stages fill.
`default_nettype none

module hsv_to_rgb_packed
    import hsvr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    hsvr_hsv_if.sink   hsv,
    hsvr_rgb_if.source rgb
);

    localparam int unsigned F    = FRAC_BITS;
    localparam int unsigned VS_W = F + CHAN_W;
    localparam int unsigned HI_W = VS_W + F + 1;
    localparam int unsigned LO_W = VS_W + F;

    logic              p_valid, p_ready;
    hsvr_ctl_t         p_ctl;
    logic [F-1:0]      p_frac;
    logic [F:0]        p_sat;
    logic [VS_W-1:0]   p_vs;

    logic              m_valid, m_ready;
    hsvr_ctl_t         m_ctl;
    logic [CHAN_W-1:0] m_vi, m_aa;
    logic [HI_W-1:0]   m_hi_b, m_hi_c;
    logic [LO_W-1:0]   m_lo_b, m_lo_c;

    hsvr_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (hsv.valid),
        .up_ready   (hsv.ready),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .dn_valid   (p_valid),
        .dn_ready   (p_ready),
        .ctl        (p_ctl),
        .frac       (p_frac),
        .sat        (p_sat),
        .vs         (p_vs)
    );

    hsvr_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (p_valid),
        .up_ready (p_ready),
        .up_ctl   (p_ctl),
        .frac     (p_frac),
        .sat      (p_sat),
        .vs       (p_vs),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_ctl   (m_ctl),
        .vi       (m_vi),
        .aa       (m_aa),
        .hi_b     (m_hi_b),
        .lo_b     (m_lo_b),
        .hi_c     (m_hi_c),
        .lo_c     (m_lo_c)
    );

    hsvr_pick #(.FRAC_BITS(FRAC_BITS)) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (m_valid),
        .up_ready (m_ready),
        .ctl      (m_ctl),
        .vi       (m_vi),
        .aa       (m_aa),
        .hi_b     (m_hi_b),
        .lo_b     (m_lo_b),
        .hi_c     (m_hi_c),
        .lo_c     (m_lo_c),
        .dn_valid (rgb.valid),
        .dn_ready (rgb.ready),
        .rgb_word (rgb.rgb_word)
    );

endmodule

`default_nettype wire
